// ===== src/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY   = 16;
    localparam int SPQ_DATA_WIDTH = 32;
    localparam int SPQ_PRIO_WIDTH = 16;

    // Encoding of the kind field on the input channel.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Operation applied to every cell of the row.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } spq_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    // Per-cell control: the row operation, whether this slot is occupied,
    // and whether the left neighbor keeps its entry on an insert.
    typedef struct packed {
        spq_op_t op;
        logic    occ;
        logic    keep_left;
    } spq_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int DATA_WIDTH = SPQ_DATA_WIDTH,
    parameter int PRIO_WIDTH = SPQ_PRIO_WIDTH
) (
    input  logic                         aclk,
    input  spq_ctrl_t                    ctrl,
    input  logic        [DATA_WIDTH-1:0] new_data,
    input  logic signed [PRIO_WIDTH-1:0] new_prio,
    input  logic        [DATA_WIDTH-1:0] left_data,
    input  logic signed [PRIO_WIDTH-1:0] left_prio,
    input  logic        [DATA_WIDTH-1:0] right_data,
    input  logic signed [PRIO_WIDTH-1:0] right_prio,
    output logic        [DATA_WIDTH-1:0] data,
    output logic signed [PRIO_WIDTH-1:0] prio,
    output logic                         keep
);

    logic        [DATA_WIDTH-1:0] data_reg;
    logic        [DATA_WIDTH-1:0] data_next;
    logic signed [PRIO_WIDTH-1:0] prio_reg;
    logic signed [PRIO_WIDTH-1:0] prio_next;

    // An occupied slot whose priority is the same or higher stays in place,
    // which keeps equal priorities in arrival order.
    assign keep = ctrl.occ && (prio_reg >= new_prio);

    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        case (ctrl.op)
            OP_INSERT: begin
                if (!keep) begin
                    if (ctrl.keep_left) begin
                        data_next = new_data;
                        prio_next = new_prio;
                    end else begin
                        data_next = left_data;
                        prio_next = left_prio;
                    end
                end
            end
            OP_REMOVE: begin
                data_next = right_data;
                prio_next = right_prio;
            end
            default: begin
                data_next = data_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

// ===== src/stable_priority_queue_unit.sv =====
// Top level of the stable priority queue: a row of sorting cells and a result register.
`timescale 1ns / 1ps
//
// Usage. Each transfer on the s_ channel is one command: s_tuser selects an
// insert (0) or a removal of the front entry (1); s_tdata carries the payload
// and the signed priority of an inserted entry. Entries leave in order of
// descending priority, and entries of equal priority leave in arrival order.
// For every command exactly one result transfer appears on the m_ channel:
// the front entry after the command, the entry count, a front-valid flag and
// a status (ok, removal on empty ignored, insert on full dropped).
// Operation: the row of cells compares every slot against the
// new priority and shifts in the same cycle, so a command updates the row in
// the cycle it is taken and its result is presented in the next cycle. One
// command is taken per cycle while results are drained; the result register
// sets that figure.
// Stalls: when m_tready is low and a result is held, s_tready drops and no
// command is taken until the result is transferred.
// Reset: aresetn low clears the count and the result valid flag; the queue is
// empty afterward and slot contents are ignored until written.

module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY   = SPQ_CAPACITY,
    parameter int DATA_WIDTH = SPQ_DATA_WIDTH,
    parameter int PRIO_WIDTH = SPQ_PRIO_WIDTH,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int S_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: payload, priority_req, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: front_payload, front_priority, count, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: front_valid, status
    output logic [2:0]           m_tuser
);

    // Input unpacking.
    logic        [DATA_WIDTH-1:0] in_data;
    logic signed [PRIO_WIDTH-1:0] in_prio;
    logic                         accept;

    assign in_data = s_tdata[DATA_WIDTH-1:0];
    assign in_prio = s_tdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH];

    // Queue occupancy.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_full;
    logic             is_empty;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Result register.
    logic                         m_tvalid_reg;
    logic                         res_valid_reg;
    logic        [DATA_WIDTH-1:0] res_data_reg;
    logic signed [PRIO_WIDTH-1:0] res_prio_reg;
    logic        [CNT_W-1:0]      res_count_reg;
    spq_status_t                  res_status_reg;

    logic                         res_valid_next;
    logic        [DATA_WIDTH-1:0] res_data_next;
    logic signed [PRIO_WIDTH-1:0] res_prio_next;
    spq_status_t                  res_status_next;

    // The input side is free whenever the result register is empty or is
    // being drained in this same cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Operation applied to the whole row this cycle.
    spq_op_t row_op;

    always_comb begin
        row_op          = OP_HOLD;
        res_status_next = STATUS_OK;
        if (accept) begin
            if (s_tuser == KIND_INSERT) begin
                if (is_full) begin
                    res_status_next = STATUS_FULL;
                end else begin
                    row_op = OP_INSERT;
                end
            end else begin
                if (is_empty) begin
                    res_status_next = STATUS_EMPTY;
                end else begin
                    row_op = OP_REMOVE;
                end
            end
        end
    end

    always_comb begin
        case (row_op)
            OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_REMOVE: count_next = count_reg - CNT_W'(1);
            default:   count_next = count_reg;
        endcase
    end

    // The row of cells. Slot 0 is the front; a slot is occupied when its
    // index lies below the count, since the entries are always contiguous.
    logic        [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic signed [PRIO_WIDTH-1:0] cell_prio [CAPACITY];
    logic                         cell_keep [CAPACITY];
    spq_ctrl_t                    cell_ctrl [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic        [DATA_WIDTH-1:0] left_data;
        logic signed [PRIO_WIDTH-1:0] left_prio;
        logic        [DATA_WIDTH-1:0] right_data;
        logic signed [PRIO_WIDTH-1:0] right_prio;

        if (i == 0) begin : g_first
            // The front slot has nothing on its left that keeps an entry
            // ahead of the new one, so it behaves as if its left kept.
            assign left_data           = in_data;
            assign left_prio           = in_prio;
            assign cell_ctrl[i].keep_left = 1'b1;
        end else begin : g_inner
            assign left_data           = cell_data[i-1];
            assign left_prio           = cell_prio[i-1];
            assign cell_ctrl[i].keep_left = cell_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = '0;
            assign right_prio = '0;
        end else begin : g_body
            assign right_data = cell_data[i+1];
            assign right_prio = cell_prio[i+1];
        end

        assign cell_ctrl[i].op  = row_op;
        assign cell_ctrl[i].occ = (CNT_W'(i) < count_reg);

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .new_data   (in_data),
            .new_prio   (in_prio),
            .left_data  (left_data),
            .left_prio  (left_prio),
            .right_data (right_data),
            .right_prio (right_prio),
            .data       (cell_data[i]),
            .prio       (cell_prio[i]),
            .keep       (cell_keep[i])
        );
    end

    // Front entry after this command, worked out from the current row so the
    // result is ready together with the row update.
    always_comb begin
        res_valid_next = (count_next != '0);
        res_data_next  = '0;
        res_prio_next  = '0;
        case (row_op)
            OP_INSERT: begin
                if (cell_keep[0]) begin
                    res_data_next = cell_data[0];
                    res_prio_next = cell_prio[0];
                end else begin
                    res_data_next = in_data;
                    res_prio_next = in_prio;
                end
            end
            OP_REMOVE: begin
                if (res_valid_next) begin
                    res_data_next = cell_data[1];
                    res_prio_next = cell_prio[1];
                end
            end
            default: begin
                if (!is_empty) begin
                    res_data_next = cell_data[0];
                    res_prio_next = cell_prio[0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_valid_reg  <= res_valid_next;
            res_data_reg   <= res_data_next;
            res_prio_reg   <= res_prio_next;
            res_count_reg  <= count_next;
            res_status_reg <= res_status_next;
        end
    end

    // Output packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({res_count_reg, res_prio_reg, res_data_reg});
    assign m_tuser  = {res_status_reg, res_valid_reg};

`ifndef SYNTH
    // The count never runs past the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A taken insert into a queue with room grows the count by one.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == KIND_INSERT) && !is_full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    // An insert into a full queue is reported as dropped.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == KIND_INSERT) && is_full
        |=> m_tvalid_reg && (res_status_reg == STATUS_FULL) && is_full)
        else $error("insert on full not flagged");

    // The front-valid flag of a result agrees with its count.
    a_front_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (res_valid_reg == (res_count_reg != '0)))
        else $error("front flag disagrees with count");

    // The two front slots stay in descending priority order.
    a_sorted_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("front slots out of order");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the stable priority queue unit.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int S_W        = 48;
    localparam int M_W        = 56;
    localparam int CYCLE_CAP  = 300000;
    localparam int RAND_ITEMS = 800;

    // One result of the queue as it appears after a command.
    typedef struct {
        logic               front_valid;
        logic [31:0]        front_payload;
        logic signed [15:0] front_priority;
        logic [4:0]         count;
        spq_status_t        status;
    } queue_view_t;

    // Keeps a sorted copy of the queue and the views that the block still owes.
    class queue_scoreboard;
        logic [31:0]        slot_payload [SPQ_CAPACITY];
        logic signed [15:0] slot_prio [SPQ_CAPACITY];
        int                 held;
        queue_view_t        owed_views [$];
        int                 mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_views.size();
        endfunction

        // Applies one accepted command to the shadow queue and records the view.
        function void note_command(logic kind, logic [31:0] payload,
                                   logic signed [15:0] prio);
            queue_view_t view;
            int          pos;
            view.status = STATUS_OK;
            if (kind == KIND_INSERT) begin
                if (held >= SPQ_CAPACITY) begin
                    view.status = STATUS_FULL;
                end else begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < held && slot_prio[pos] >= prio) pos++;
                    for (int i = held; i > pos; i--) begin
                        slot_payload[i] = slot_payload[i-1];
                        slot_prio[i]    = slot_prio[i-1];
                    end
                    slot_payload[pos] = payload;
                    slot_prio[pos]    = prio;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    view.status = STATUS_EMPTY;
                end else begin
                    for (int i = 1; i < held; i++) begin
                        slot_payload[i-1] = slot_payload[i];
                        slot_prio[i-1]    = slot_prio[i];
                    end
                    held--;
                end
            end
            view.front_valid    = (held > 0);
            view.front_payload  = (held > 0) ? slot_payload[0] : 32'd0;
            view.front_priority = (held > 0) ? slot_prio[0] : 16'sd0;
            view.count          = 5'(held);
            owed_views.push_back(view);
        endfunction

        // Compares one result transfer with the oldest owed view.
        function void check_result(logic [M_W-1:0] tdata, logic [2:0] tuser);
            queue_view_t want;
            queue_view_t got;
            logic        bad;
            got.front_payload  = tdata[31:0];
            got.front_priority = tdata[47:32];
            got.count          = tdata[52:48];
            got.front_valid    = tuser[0];
            got.status         = spq_status_t'(tuser[2:1]);
            if (owed_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing owed: valid=%0d payload=%h prio=%0d",
                             $realtime, got.front_valid, got.front_payload,
                             got.front_priority);
                return;
            end
            want = owed_views.pop_front();
            bad  = (got.front_valid !== want.front_valid)
                || (got.front_payload !== want.front_payload)
                || (got.front_priority !== want.front_priority)
                || (got.count !== want.count)
                || (got.status !== want.status)
                || (tdata[M_W-1:53] !== '0);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch, expected valid=%0d payload=%h prio=%0d count=%0d status=%0d",
                             $realtime, want.front_valid, want.front_payload,
                             want.front_priority, want.count, want.status);
                    $display("%0t:            got valid=%0d payload=%h prio=%0d count=%0d status=%0d fill=%h",
                             $realtime, got.front_valid, got.front_payload,
                             got.front_priority, got.count, got.status, tdata[M_W-1:53]);
                end
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    // s_tdata: payload, priority_req
    logic [S_W-1:0] s_tdata;
    // s_tuser: kind
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    // m_tdata: front_payload, front_priority, count, zero fill
    logic [M_W-1:0] m_tdata;
    // m_tuser: front_valid, status
    logic [2:0]     m_tuser;

    queue_scoreboard sb;
    bit              quiet;
    int unsigned     cycle_count;

    stable_priority_queue_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Every transfer is recorded at the rising edge where it happens. Commands
    // are noted before results are checked, so a result owed by a command
    // accepted at this same edge can never be missed.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // Result side: before every result it holds m_tready low for a random
    // number of cycles, then keeps it high until a transfer takes place.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Presents one command after a random gap and holds it until it is taken.
    // Called and returns at a falling edge; s_tvalid stays high on return so
    // back-to-back commands keep the channel busy.
    task automatic send_command(input logic kind, input logic [31:0] payload,
                                input logic [15:0] prio);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, payload};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops the command side until the block has delivered every result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // Priorities are mostly drawn from a narrow band so that ties are common,
    // which exercises the arrival-order rule; the rest spans the whole range.
    function automatic logic [15:0] draw_priority();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)      return 16'($urandom_range(0, 7)) - 16'd4;
        else if (pick <= 7) return 16'($urandom);
        else if (pick == 8) return 16'h7fff;
        else                return 16'h8000;
    endfunction

    initial begin
        int insert_pct;
        sb          = new();
        quiet       = 1'b0;
        cycle_count = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_INSERT;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A removal on the empty queue comes first.
        send_command(KIND_REMOVE, 32'hdead_beef, 16'h1234);
        // Extremes of payload and priority, with ties at zero and at the top.
        send_command(KIND_INSERT, 32'h0000_0000, 16'h0000);
        send_command(KIND_INSERT, 32'hffff_ffff, 16'h7fff);
        send_command(KIND_INSERT, 32'h0000_0001, 16'h8000);
        send_command(KIND_INSERT, 32'h0000_0002, 16'h0000);
        send_command(KIND_INSERT, 32'h0000_0003, 16'hffff);
        send_command(KIND_INSERT, 32'h0000_0004, 16'h7fff);
        // Fill the remaining slots with one shared priority.
        for (int i = 0; i < 10; i++)
            send_command(KIND_INSERT, 32'ha5a5_0000 + 32'(i), 16'h0005);
        // The queue is full now, so this insert is dropped even at top priority.
        send_command(KIND_INSERT, 32'h5a5a_5a5a, 16'h7fff);
        for (int i = 0; i < 3; i++)
            send_command(KIND_REMOVE, $urandom, 16'($urandom));
        drain_results();

        // Random part in bursts. Each burst leans toward inserts, removals or
        // neither, so the queue swings between empty and full many times.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 50;
                    default: insert_pct = 20;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == RAND_ITEMS / 2)
                drain_results();
            if ($urandom_range(0, 99) < insert_pct)
                send_command(KIND_INSERT, $urandom, draw_priority());
            else
                send_command(KIND_REMOVE, $urandom, 16'($urandom));
        end

        s_tvalid <= 1'b0;
        quiet = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // A final wait catches any result the block sends without cause.
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
